// ===== rtl/core/tfrm_pkg.sv =====
package tfrm_pkg;

  localparam int NUM_FANS_DEF = 4;

  localparam int OP_W    = 2;
  localparam int CH_W    = 3;
  localparam int STAMP_W = 16;
  localparam int RATE_W  = 16;
  localparam int IPL_W   = 16;
  localparam int STAT_W  = 2;
  localparam int DIV_W   = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [OP_W-1:0] OP_CAPTURE = 2'd0;
  localparam logic [OP_W-1:0] OP_WINDOW  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_START = 2'd2;
  localparam logic [IPL_W-1:0]  IPL_RESET    = 16'd169;
  localparam logic [DIV_W-1:0]  FAN_NUM      = 32'd7500000;
  localparam logic [DIV_W-1:0]  FLOW_NUM     = 32'd450000000;
  localparam logic [RATE_W-1:0] RATE_MAX     = 16'hFFFF;
  localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(DIV_W - 1);

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CH_W-1:0]    channel;
    logic [STAMP_W-1:0] stamp;
  } tfrm_in_t;

  typedef struct packed {
    logic [CH_W-1:0]   chan_out;
    logic [RATE_W-1:0] rate;
    logic              saturated;
  } tfrm_out_t;

  // read request handed from front to back
  typedef struct packed {
    logic [CH_W-1:0]    chan_out;
    logic               ok;
    logic               flow;
    logic [STAMP_W-1:0] period;
    logic [IPL_W-1:0]   ipl;
  } tfrm_req_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_DONE
  } tfrm_back_state_t;

endpackage

// ===== rtl/core/tfrm_front.sv =====
module tfrm_front #(
  parameter int NUM_FANS = tfrm_pkg::NUM_FANS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  tfrm_pkg::tfrm_in_t              in_data,
  input  logic                            req_full,
  output logic                            req_push,
  output tfrm_pkg::tfrm_req_t             req_data,
  input  logic                            cfg_we,
  input  logic [tfrm_pkg::IPL_W-1:0]      cfg_wdata
);

  localparam int NCH   = NUM_FANS + 1;
  localparam int IDX_W = $clog2(NCH);
  localparam int EXT_W = (IDX_W > tfrm_pkg::CH_W) ? IDX_W : tfrm_pkg::CH_W;

  logic [tfrm_pkg::STAMP_W-1:0] last_stamp_r [NCH];
  logic [tfrm_pkg::STAMP_W-1:0] last_stamp_nxt [NCH];
  logic [tfrm_pkg::STAMP_W-1:0] period_r [NCH];
  logic [tfrm_pkg::STAMP_W-1:0] period_nxt [NCH];
  logic [tfrm_pkg::STAT_W-1:0]  edge_r [NCH];
  logic [tfrm_pkg::STAT_W-1:0]  edge_nxt [NCH];
  logic [tfrm_pkg::STAT_W-1:0]  latched_r [NCH];
  logic [tfrm_pkg::STAT_W-1:0]  latched_nxt [NCH];
  logic [tfrm_pkg::IPL_W-1:0]   ipl_r;
  logic [tfrm_pkg::IPL_W-1:0]   ipl_nxt;

  logic             accept;
  logic [EXT_W:0]   ch_ext;
  logic             ch_ok;
  logic [IDX_W-1:0] idx;

  assign accept = push && !req_full;
  assign ch_ext = (EXT_W+1)'(in_data.channel);
  assign ch_ok  = ch_ext < (EXT_W+1)'(NCH);
  assign idx    = ch_ok ? ch_ext[IDX_W-1:0] : '0;

  assign ipl_nxt = cfg_we ? cfg_wdata : ipl_r;

  always_comb begin
    last_stamp_nxt = last_stamp_r;
    period_nxt     = period_r;
    edge_nxt       = edge_r;
    latched_nxt    = latched_r;
    if (accept) begin
      unique case (in_data.op)
        tfrm_pkg::OP_CAPTURE: begin
          if (ch_ok) begin
            if (edge_r[idx] < tfrm_pkg::STATUS_START) begin
              period_nxt[idx] = in_data.stamp - last_stamp_r[idx];
            end
            last_stamp_nxt[idx] = in_data.stamp;
            if (edge_r[idx] != '0) begin
              edge_nxt[idx] = edge_r[idx] - 1'b1;
            end
          end
        end
        tfrm_pkg::OP_WINDOW: begin
          for (int i = 0; i < NCH; i++) begin
            latched_nxt[i] = edge_r[i];
            edge_nxt[i]    = tfrm_pkg::STATUS_START;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign req_push          = accept && (in_data.op == tfrm_pkg::OP_READ);
  assign req_data.chan_out = in_data.channel;
  assign req_data.ok       = ch_ok && (latched_r[idx] == '0);
  assign req_data.flow     = (idx == '0);
  assign req_data.period   = period_r[idx];
  assign req_data.ipl      = ipl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        last_stamp_r[i] <= '0;
        period_r[i]     <= '0;
        edge_r[i]       <= tfrm_pkg::STATUS_START;
        latched_r[i]    <= tfrm_pkg::STATUS_START;
      end
      ipl_r <= tfrm_pkg::IPL_RESET;
    end else begin
      last_stamp_r <= last_stamp_nxt;
      period_r     <= period_nxt;
      edge_r       <= edge_nxt;
      latched_r    <= latched_nxt;
      ipl_r        <= ipl_nxt;
    end
  end

endmodule

// ===== rtl/core/tfrm_fifo.sv =====
module tfrm_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tfrm_pkg::tfrm_req_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output tfrm_pkg::tfrm_req_t head
);

  localparam int DEPTH = tfrm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tfrm_pkg::tfrm_req_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/tfrm_back.sv =====
module tfrm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_empty,
  input  tfrm_pkg::tfrm_req_t req_head,
  output logic                req_pop,
  output logic                empty,
  input  logic                pop,
  output tfrm_pkg::tfrm_out_t out_data
);

  localparam int DW = tfrm_pkg::DIV_W;

  tfrm_pkg::tfrm_back_state_t state_r, state_nxt;
  tfrm_pkg::tfrm_req_t        req_r, req_nxt;
  logic [DW-1:0]              den_r, den_nxt;
  logic [DW-1:0]              rem_r, rem_nxt;
  logic [DW-1:0]              quo_r, quo_nxt;
  logic [tfrm_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  tfrm_pkg::tfrm_out_t        out_r, out_nxt;

  logic        ld_div, div_step, wr_out;
  logic [DW:0] rem_sh;
  logic        ge;
  tfrm_pkg::tfrm_out_t result;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tfrm_pkg::B_IDLE: begin
        if (!req_empty) begin
          state_nxt = tfrm_pkg::B_MUL;
        end
      end
      tfrm_pkg::B_MUL: begin
        state_nxt = tfrm_pkg::B_DIV;
      end
      tfrm_pkg::B_DIV: begin
        if (cnt_r == tfrm_pkg::DIV_CNT_LAST) begin
          state_nxt = tfrm_pkg::B_DONE;
        end
      end
      tfrm_pkg::B_DONE: begin
        if (!out_valid_r || pop) begin
          state_nxt = tfrm_pkg::B_IDLE;
        end
      end
      default: state_nxt = tfrm_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    req_pop  = 1'b0;
    ld_div   = 1'b0;
    div_step = 1'b0;
    wr_out   = 1'b0;
    unique case (state_r)
      tfrm_pkg::B_IDLE: req_pop  = !req_empty;
      tfrm_pkg::B_MUL:  ld_div   = 1'b1;
      tfrm_pkg::B_DIV:  div_step = 1'b1;
      tfrm_pkg::B_DONE: wr_out   = !out_valid_r || pop;
      default: begin
      end
    endcase
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    result.chan_out = req_r.chan_out;
    if (!req_r.ok) begin
      result.rate      = '0;
      result.saturated = 1'b0;
    end else if ((den_r == '0) || (quo_r[DW-1:tfrm_pkg::RATE_W] != '0)) begin
      result.rate      = tfrm_pkg::RATE_MAX;
      result.saturated = 1'b1;
    end else begin
      result.rate      = quo_r[tfrm_pkg::RATE_W-1:0];
      result.saturated = 1'b0;
    end
  end

  always_comb begin
    req_nxt = req_pop ? req_head : req_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (ld_div) begin
      den_nxt = req_r.flow ? DW'(req_r.period) * DW'(req_r.ipl)
                           : DW'({req_r.period, 1'b0});
      rem_nxt = '0;
      quo_nxt = req_r.flow ? tfrm_pkg::FLOW_NUM : tfrm_pkg::FAN_NUM;
      cnt_nxt = '0;
    end else if (div_step) begin
      rem_nxt = ge ? DW'(rem_sh - {1'b0, den_r}) : rem_sh[DW-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (wr_out) begin
      out_valid_nxt = 1'b1;
      out_nxt       = result;
    end else if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign empty    = !out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tfrm_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req_pop |-> (state_r == tfrm_pkg::B_IDLE) && !req_empty)
    else $error("request dequeued outside idle");

  a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tfrm_pkg::B_MUL) |=> (state_r == tfrm_pkg::B_DIV) && (cnt_r == '0))
    else $error("divider not started after multiply");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tfrm_pkg::B_DIV) && (cnt_r != tfrm_pkg::DIV_CNT_LAST)
    |=> (state_r == tfrm_pkg::B_DIV) && (cnt_r == $past(cnt_r) + 1'b1))
    else $error("divider step count broken");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.saturated |-> out_r.rate == tfrm_pkg::RATE_MAX)
    else $error("saturated result without full-scale rate");
`endif

endmodule

// ===== rtl/core/tach_flow_rate_meter_core.sv =====
// Channel  Handshake        Payload
// input    push / full      in_data   (op, channel, stamp)
// result   empty / pop      out_data  (chan_out, rate, saturated)
// config   cfg_we           cfg_wdata (impulses_per_liter)
//
// Capture and window-end requests finish in the cycle they are accepted.
// A read request passes through the divide engine as dequeue, multiply,
// 32 restoring divide steps, result write; reads are served one at a time.
// Up to two reads queue ahead of the divider; full rises when both are held,
// and a finished result waits in the output register until popped.
// Synchronous active-low reset; no clearing pass.
module tach_flow_rate_meter_core #(
  parameter int NUM_FANS = tfrm_pkg::NUM_FANS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  tfrm_pkg::tfrm_in_t         in_data,
  output logic                       empty,
  input  logic                       pop,
  output tfrm_pkg::tfrm_out_t        out_data,
  input  logic                       cfg_we,
  input  logic [tfrm_pkg::IPL_W-1:0] cfg_wdata
);

  logic                req_push;
  tfrm_pkg::tfrm_req_t req_data;
  logic                req_full;
  logic                req_pop;
  logic                req_empty;
  tfrm_pkg::tfrm_req_t req_head;

  assign full = req_full;

  tfrm_front #(
    .NUM_FANS (NUM_FANS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .req_full  (req_full),
    .req_push  (req_push),
    .req_data  (req_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tfrm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (req_push),
    .push_data (req_data),
    .full      (req_full),
    .pop       (req_pop),
    .empty     (req_empty),
    .head      (req_head)
  );

  tfrm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_empty (req_empty),
    .req_head  (req_head),
    .req_pop   (req_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule
